>>> hdl/hse_pkg.sv
// Shared types and constants of the subset histogram estimator.
package hse_pkg;

  localparam int VALUE_BITS    = 10;
  localparam int GAIN_BITS     = 32;
  localparam int EST_BITS      = 64;
  localparam int CNT_WORD_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCALE_GAIN      = 1'b0,
    REG_BIAS_PER_REPORT = 1'b1
  } cfg_reg_t;

  // Operands of one query, handed from the histogram stage to the estimate stage.
  typedef struct packed {
    logic [CNT_WORD_BITS-1:0] cnt;
    logic [CNT_WORD_BITS-1:0] reports;
    logic                     sticky;
  } hse_query_t;

  localparam logic signed [EST_BITS-1:0] EST_MAX = {1'b0, {(EST_BITS-1){1'b1}}};
  localparam logic signed [EST_BITS-1:0] EST_MIN = {1'b1, {(EST_BITS-1){1'b0}}};

endpackage

>>> hdl/hse_if.sv
// Channel interfaces of the subset histogram estimator: input, result and configuration.
interface hse_in_if import hse_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [VALUE_BITS-1:0] item_value;
  logic                  end_of_report;

  modport source (output valid, cmd, item_value, end_of_report, input ready);
  modport sink   (input valid, cmd, item_value, end_of_report, output ready);
endinterface

interface hse_out_if import hse_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [EST_BITS-1:0] estimate;
  logic                       clipped;

  modport source (output valid, estimate, clipped, input ready);
  modport sink   (input valid, estimate, clipped, output ready);
endinterface

interface hse_cfg_if import hse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [GAIN_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/hse_hist.sv
// Histogram stage: count memory with clearing pass, read-modify-write with forwarding, report counter.
module hse_hist import hse_pkg::*; #(
  parameter int UNIVERSE_SIZE = 1024,
  parameter int COUNT_BITS    = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  hse_in_if.sink     in_ch,
  output logic       q_valid,
  input  logic       q_ready,
  output hse_query_t q_data
);

  localparam int AW = (UNIVERSE_SIZE > 1) ? $clog2(UNIVERSE_SIZE) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [AW-1:0]         LAST_ADR = AW'(UNIVERSE_SIZE - 1);

  logic [COUNT_BITS-1:0] mem [UNIVERSE_SIZE];

  logic                  clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  s1_vld_r, s1_vld_nxt;
  logic                  s1_cmd_r;
  logic [AW-1:0]         s1_addr_r;
  logic                  s1_hit_r;
  logic                  s1_eor_r;
  logic [COUNT_BITS-1:0] rd_r;
  logic                  fwd_vld_r, fwd_vld_nxt;
  logic [AW-1:0]         fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [COUNT_BITS-1:0] reports_r, reports_nxt;
  logic                  sticky_r, sticky_nxt;

  logic                  accept;
  logic                  in_range;
  logic [AW-1:0]         in_addr;
  logic                  s1_is_add;
  logic                  s1_go;
  logic                  add_go;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  cnt_full;
  logic [COUNT_BITS-1:0] cnt_bump;
  logic                  rep_full;

  assign accept   = in_ch.valid & in_ch.ready;
  assign in_range = 32'(in_ch.item_value) < UNIVERSE_SIZE;
  assign in_addr  = AW'(in_ch.item_value);

  assign s1_is_add = (s1_cmd_r == CMD_ADD);
  assign s1_go     = s1_vld_r & (s1_is_add | q_ready);
  assign add_go    = s1_go & s1_is_add;
  assign wr_en     = add_go & s1_hit_r;

  assign in_ch.ready = ~clr_busy_r & (~s1_vld_r | s1_go);

  // The write made at the edge that read this item's count is not yet in the read data.
  assign cur_cnt  = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_r;
  assign cnt_full = (cur_cnt == CNT_MAX);
  assign cnt_bump = cnt_full ? cur_cnt : cur_cnt + 1'b1;
  assign rep_full = (reports_r == CNT_MAX);

  assign q_valid        = s1_vld_r & ~s1_is_add;
  assign q_data.cnt     = s1_hit_r ? CNT_WORD_BITS'(cur_cnt) : '0;
  assign q_data.reports = CNT_WORD_BITS'(reports_r);
  assign q_data.sticky  = sticky_r;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADR) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end

    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end

    fwd_vld_nxt = accept ? wr_en : fwd_vld_r;

    reports_nxt = reports_r;
    sticky_nxt  = sticky_r | (wr_en & cnt_full);
    if (add_go && s1_eor_r) begin
      if (rep_full) begin
        sticky_nxt = 1'b1;
      end else begin
        reports_nxt = reports_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      reports_r  <= '0;
      sticky_r   <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_vld_r   <= s1_vld_nxt;
      fwd_vld_r  <= fwd_vld_nxt;
      reports_r  <= reports_nxt;
      sticky_r   <= sticky_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r   <= in_ch.cmd;
      s1_addr_r  <= in_addr;
      s1_hit_r   <= in_range;
      s1_eor_r   <= in_ch.end_of_report;
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= cnt_bump;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[s1_addr_r] <= cnt_bump;
    end
    if (accept) begin
      rd_r <= mem[in_addr];
    end
  end

endmodule

>>> hdl/hse_est.sv
// Estimate stage: two gain products, then saturating sum into the result register.
module hse_est import hse_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  hse_query_t                  q_data,
  input  logic signed [GAIN_BITS-1:0] gain,
  input  logic signed [GAIN_BITS-1:0] bias,
  hse_out_if.source                   out_ch
);

  logic                       s2_vld_r, s2_vld_nxt;
  logic signed [EST_BITS-1:0] p1_r;
  logic signed [EST_BITS-1:0] p2_r;
  logic                       stk_r;
  logic                       out_vld_r, out_vld_nxt;
  logic signed [EST_BITS-1:0] est_r;
  logic                       clip_r;

  logic                       s3_free;
  logic                       q_take;
  logic                       s2_go;
  logic signed [EST_BITS:0]   prod1;
  logic signed [EST_BITS:0]   prod2;
  logic signed [EST_BITS:0]   sum;
  logic                       ovf;
  logic signed [EST_BITS-1:0] est_sat;

  assign s3_free = ~out_vld_r | out_ch.ready;
  assign q_ready = ~s2_vld_r | s3_free;
  assign q_take  = q_valid & q_ready;
  assign s2_go   = s2_vld_r & s3_free;

  // Counts are unsigned, so they enter the signed products with a zero on top.
  assign prod1 = (EST_BITS+1)'(gain) * (EST_BITS+1)'($signed({1'b0, q_data.cnt}));
  assign prod2 = (EST_BITS+1)'(bias) * (EST_BITS+1)'($signed({1'b0, q_data.reports}));

  assign sum     = {p1_r[EST_BITS-1], p1_r} + {p2_r[EST_BITS-1], p2_r};
  assign ovf     = sum[EST_BITS] ^ sum[EST_BITS-1];
  assign est_sat = ovf ? (sum[EST_BITS] ? EST_MIN : EST_MAX) : sum[EST_BITS-1:0];

  assign out_ch.valid    = out_vld_r;
  assign out_ch.estimate = est_r;
  assign out_ch.clipped  = clip_r;

  always_comb begin
    if (q_take) begin
      s2_vld_nxt = 1'b1;
    end else if (s3_free) begin
      s2_vld_nxt = 1'b0;
    end else begin
      s2_vld_nxt = s2_vld_r;
    end

    if (s2_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      p1_r  <= prod1[EST_BITS-1:0];
      p2_r  <= prod2[EST_BITS-1:0];
      stk_r <= q_data.sticky;
    end
    if (s2_go) begin
      est_r  <= est_sat;
      clip_r <= ovf | stk_r;
    end
  end

endmodule

>>> hdl/subset_histogram_estimator.sv
// Subset histogram estimator top: configuration registers, histogram and estimate stages.

// The block takes one word per clock on in_ch while in_ch.ready is high. An add word
// (cmd 0) bumps the count of its value and, with end_of_report set, the report counter;
// it gives no result. A query word (cmd 1) returns scale_gain * count + bias_per_report *
// reports as a saturated signed Q48.16 estimate on out_ch once it is taken: the histogram
// memory is read at the accepting edge, then the two gain products are registered, then
// the saturating sum is registered into the result register. Adds and
// queries may follow each other in every cycle, to the same value too, because the count
// written at one edge is forwarded to the word read at that edge. Result backpressure stalls
// input only once the multiplier and output registers are both full. After reset the
// count memory is cleared one entry a cycle, so in_ch.ready stays low until the last
// entry is cleared; configuration writes are taken at all times, cfg_ch.ready is always high.
// Values at or above UNIVERSE_SIZE are not counted and query as zero. Counters stop at
// their maximum and then set a sticky flag that marks every later estimate as clipped.
module subset_histogram_estimator import hse_pkg::*; #(
  parameter int UNIVERSE_SIZE = 1024,
  parameter int COUNT_BITS    = 24
) (
  input logic       clk,
  input logic       rst_n,
  hse_in_if.sink    in_ch,
  hse_out_if.source out_ch,
  hse_cfg_if.sink   cfg_ch
);

  // Gain registers, both signed Q16.16; the gain on a count resets to 1.0.
  logic signed [GAIN_BITS-1:0] gain_r, gain_nxt;
  logic signed [GAIN_BITS-1:0] bias_r, bias_nxt;

  logic       cfg_wr;
  logic       q_valid;
  logic       q_ready;
  hse_query_t q_data;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid & cfg_ch.ready;

  always_comb begin
    gain_nxt = gain_r;
    bias_nxt = bias_r;
    if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_SCALE_GAIN:      gain_nxt = $signed(cfg_ch.data);
        REG_BIAS_PER_REPORT: bias_nxt = $signed(cfg_ch.data);
        default:             gain_nxt = gain_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_BITS'(65536);
      bias_r <= '0;
    end else begin
      gain_r <= gain_nxt;
      bias_r <= bias_nxt;
    end
  end

  // First stage: histogram memory, its clearing pass and the report counter.
  hse_hist #(
    .UNIVERSE_SIZE (UNIVERSE_SIZE),
    .COUNT_BITS    (COUNT_BITS)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  // Second and third stages: products of the gains, then the saturating sum.
  hse_est u_est (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .gain    (gain_r),
    .bias    (bias_r),
    .out_ch  (out_ch)
  );

endmodule
